// ----- src/gsa_pkg.sv -----
package gsa_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [31:0] NO_HANDLE   = 32'hFFFF_FFFF;
  localparam logic [15:0] GEN_WRAP_AT = 16'd65534;

  // used bits are kept in words of GROUP_W slots
  localparam int GROUP_W    = 16;
  localparam int GROUP_BITS = 4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] new_handle;
    logic [15:0] slot_index;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_PICK,
    S_GEN,
    S_READ,
    S_CHECK,
    S_PUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic find;
    logic pick;
    logic gen;
    logic rd;
    logic chk;
    logic push;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_alloc;
    logic req_check;
    logic all_full;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/gsa_ctrl.sv -----
module gsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  gsa_pkg::dp_status_t status,
  output logic                req_ready,
  output gsa_pkg::dp_cmd_t    cmd
);

  gsa_pkg::state_t state;
  gsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gsa_pkg::S_IDLE: begin
        if (req_valid) begin
          if (status.req_alloc) begin
            state_next = gsa_pkg::S_FIND;
          end else if (status.req_check) begin
            state_next = gsa_pkg::S_READ;
          end else begin
            state_next = gsa_pkg::S_PUSH;
          end
        end
      end
      gsa_pkg::S_FIND: begin
        state_next = status.all_full ? gsa_pkg::S_PUSH : gsa_pkg::S_PICK;
      end
      gsa_pkg::S_PICK:  state_next = gsa_pkg::S_GEN;
      gsa_pkg::S_GEN:   state_next = gsa_pkg::S_PUSH;
      gsa_pkg::S_READ:  state_next = gsa_pkg::S_CHECK;
      gsa_pkg::S_CHECK: state_next = gsa_pkg::S_PUSH;
      gsa_pkg::S_PUSH: begin
        if (status.out_free) begin
          state_next = gsa_pkg::S_IDLE;
        end
      end
      default: state_next = gsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      gsa_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
      end
      gsa_pkg::S_FIND:  cmd.find = 1'b1;
      gsa_pkg::S_PICK:  cmd.pick = 1'b1;
      gsa_pkg::S_GEN:   cmd.gen  = 1'b1;
      gsa_pkg::S_READ:  cmd.rd   = 1'b1;
      gsa_pkg::S_CHECK: cmd.chk  = 1'b1;
      gsa_pkg::S_PUSH:  cmd.push = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/gsa_datapath.sv -----
module gsa_datapath #(
  parameter int SLOTS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  gsa_pkg::req_t       req,
  input  gsa_pkg::dp_cmd_t    cmd,
  output gsa_pkg::dp_status_t status,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output gsa_pkg::rsp_t       rsp
);

  localparam int GW       = gsa_pkg::GROUP_W;
  localparam int GB       = gsa_pkg::GROUP_BITS;
  localparam int NGROUPS  = (SLOTS + GW - 1) / GW;
  localparam int GRP_BITS = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW_BITS  = $clog2(SLOTS + 1);
  localparam int GHW_BITS = $clog2(NGROUPS + 1);
  localparam int LAST_USED = SLOTS - (NGROUPS - 1) * GW;
  // slots past the end of the table in the last word count as used
  localparam logic [GW-1:0] PAD_MASK = ~((GW'(1) << LAST_USED) - GW'(1));

  // storage
  logic [GW-1:0]        used_mem [NGROUPS];
  logic [15:0]          gen_mem  [SLOTS];
  logic [NGROUPS-1:0]   grp_full;
  logic [HW_BITS-1:0]   hw;   // slots ever allocated, always a prefix
  logic [GHW_BITS-1:0]  ghw;  // words ever written, always a prefix

  // working registers
  logic [1:0]           cmd_q;
  logic [31:0]          hnd_q;
  logic [GRP_BITS-1:0]  grp_q;
  logic [IDX_BITS-1:0]  idx_q;
  logic                 fresh_q;
  logic [GW-1:0]        word_q;
  logic [15:0]          gen_q;
  gsa_pkg::rsp_t        res;

  // combinational
  logic [15:0]          h_idx;
  logic [15:0]          h_gen;
  logic [GRP_BITS-1:0]  h_grp;
  logic [IDX_BITS-1:0]  h_slot;
  logic [GB-1:0]        h_bit;
  logic                 h_in_range;
  logic [GRP_BITS-1:0]  find_grp;
  logic [GRP_BITS-1:0]  used_raddr;
  logic [GRP_BITS-1:0]  cur_grp;
  logic [GW-1:0]        word_live;
  logic [GW-1:0]        pad;
  logic [GB-1:0]        pick_bit;
  logic [GRP_BITS+GB-1:0] pick_wide;
  logic [IDX_BITS-1:0]  pick_idx;
  logic [GW-1:0]        pick_word;
  logic                 full_after;
  logic                 pick_fresh;
  logic [IDX_BITS-1:0]  gen_raddr;
  logic                 chk_ok;
  logic                 do_release;
  logic [15:0]          gen_old;
  logic [15:0]          gen_new;

  assign h_idx      = hnd_q[15:0];
  assign h_gen      = hnd_q[31:16];
  assign h_grp      = GRP_BITS'(h_idx >> GB);
  assign h_slot     = IDX_BITS'(h_idx);
  assign h_bit      = h_idx[GB-1:0];
  assign h_in_range = (h_idx < 16'(SLOTS));

  // lowest word that still has a free slot
  always_comb begin
    find_grp = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        find_grp = GRP_BITS'(g);
      end
    end
  end

  assign used_raddr = cmd.find ? find_grp : h_grp;
  assign cur_grp    = cmd.chk ? h_grp : grp_q;
  assign word_live  = (GHW_BITS'(cur_grp) < ghw) ? word_q : '0;
  assign pad        = (grp_q == GRP_BITS'(NGROUPS - 1)) ? PAD_MASK : '0;

  // lowest free bit in the chosen word
  always_comb begin
    pick_bit = '0;
    for (int b = GW - 1; b >= 0; b--) begin
      if (!(word_live[b] | pad[b])) begin
        pick_bit = GB'(b);
      end
    end
  end

  assign pick_wide  = {grp_q, pick_bit};
  assign pick_idx   = IDX_BITS'(pick_wide);
  assign pick_word  = word_live | (GW'(1) << pick_bit);
  assign full_after = &(pick_word | pad);
  assign pick_fresh = (HW_BITS'(pick_idx) == hw);
  assign gen_raddr  = cmd.pick ? pick_idx : h_slot;

  assign chk_ok = (hnd_q != gsa_pkg::NO_HANDLE) && h_in_range &&
                  word_live[h_bit] && (gen_q == h_gen);
  assign do_release = cmd.chk && chk_ok && (cmd_q == gsa_pkg::CMD_RELEASE);

  assign gen_old = fresh_q ? 16'd0 : gen_q;
  assign gen_new = (gen_old >= gsa_pkg::GEN_WRAP_AT) ? 16'd1 : gen_old + 16'd1;

  assign status.req_alloc = (req.command == gsa_pkg::CMD_ALLOC);
  assign status.req_check = (req.command == gsa_pkg::CMD_RELEASE) ||
                            (req.command == gsa_pkg::CMD_LOOKUP);
  assign status.all_full  = &grp_full;
  assign status.out_free  = !rsp_valid || rsp_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_full  <= '0;
      hw        <= '0;
      ghw       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.pick) begin
        grp_full[grp_q] <= full_after;
        if (pick_fresh) begin
          hw <= hw + HW_BITS'(1);
        end
        if (GHW_BITS'(grp_q) == ghw) begin
          ghw <= ghw + GHW_BITS'(1);
        end
      end else if (do_release) begin
        grp_full[h_grp] <= 1'b0;
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= req.command;
      hnd_q <= req.handle;
      res   <= '{ok: 1'b0, new_handle: gsa_pkg::NO_HANDLE, slot_index: 16'd0};
    end
    if (cmd.find) begin
      grp_q <= find_grp;
    end
    if (cmd.pick) begin
      idx_q   <= pick_idx;
      fresh_q <= pick_fresh;
    end
    if (cmd.gen) begin
      res <= '{ok: 1'b1, new_handle: {gen_new, 16'(idx_q)}, slot_index: 16'(idx_q)};
    end
    if (cmd.chk && chk_ok) begin
      res <= '{ok: 1'b1, new_handle: gsa_pkg::NO_HANDLE, slot_index: h_idx};
    end
    if (cmd.push) begin
      rsp <= res;
    end
  end

  // used-bit words
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      used_mem[grp_q] <= pick_word;
    end else if (do_release) begin
      used_mem[h_grp] <= word_live & ~(GW'(1) << h_bit);
    end
    if (cmd.find || cmd.rd) begin
      word_q <= used_mem[used_raddr];
    end
  end

  // generation store
  always_ff @(posedge clk) begin
    if (cmd.gen) begin
      gen_mem[idx_q] <= gen_new;
    end
    if (cmd.pick || cmd.rd) begin
      gen_q <= gen_mem[gen_raddr];
    end
  end

  a_full_means_all_allocated: assert property (@(posedge clk) disable iff (rst)
    (&grp_full) |-> (hw == HW_BITS'(SLOTS)))
    else $error("all words full but not every slot was ever allocated");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |-> (pick_wide < SLOTS))
    else $error("picked slot past end of table");

  a_gen_gives_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.gen |=> res.ok)
    else $error("allocate result not marked ok");

  a_live_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.chk && chk_ok) |-> (gen_q != 16'd0))
    else $error("live slot with generation zero");

endmodule

// ----- src/generational_slot_allocator.sv -----
// generational slot allocator
// keeps SLOTS slots, each with an in-use bit and a 16-bit generation
// req channel (req_valid/req_ready/req): one command per transaction,
//   allocate takes the lowest free slot, release and lookup check a handle
//   (generation in bits 31..16, index in bits 15..0)
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one result per command,
//   ok, the issued handle (all ones unless an allocate succeeded) and the slot
// one command is worked at a time by a small sequencer:
//   allocate steps through find word, pick bit, generation read-modify-write
//   and result, or through find word and result when the table is full,
//   release and lookup step through read, check and result, and an unused
//   command code goes straight to result
// these steps follow from the registered reads of the used-bit words and of
//   the generation store, one port each
// reset empties the table: used words and generations are only
//   trusted below a high-water count, so no clearing pass is run
// a stalled receiver holds the result in the output register; the next
//   command is still taken and worked, and waits to hand over its result
module generational_slot_allocator #(
  parameter int SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gsa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gsa_pkg::rsp_t rsp
);

  gsa_pkg::dp_cmd_t    cmd;     // sequencer strobes
  gsa_pkg::dp_status_t status;  // decode and flags back to sequencer

  // sequencer
  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  // slot table, search logic and output register
  gsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ----- sim/tb_generational_slot_allocator.sv -----
module tb_generational_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;

  // the one command code the block must answer with a plain failure
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  gsa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  gsa_pkg::rsp_t rsp;

  generational_slot_allocator #(
    .SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the slot table, advanced once per accepted request transaction
  logic        tbl_used [SLOTS];
  logic [15:0] tbl_gen  [SLOTS];

  // responses still owed by the block, oldest first
  gsa_pkg::rsp_t rsp_owed [$];

  // random idling on both channels; cleared for long no-gap stretches
  bit idle_on = 1'b1;
  // receiver hold-off length, counted down by the receiver process
  int rsp_hold_cycles = 0;

  int err_count = 0;
  int n_checked = 0;
  int n_cmd [4] = '{0, 0, 0, 0};
  int n_ok = 0;
  int n_refused = 0;

  function automatic logic [31:0] mk_handle(input logic [15:0] g, input int s);
    return {g, 16'(s)};
  endfunction

  function automatic int first_free_slot();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      if (!tbl_used[s]) return s;
    end
    return -1;
  endfunction

  // some slot in the wanted state, starting the scan at a random point
  function automatic int find_slot(input logic want_used);
    int start;
    int k;
    int s;
    start = $urandom_range(SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      s = (start + k) % SLOTS;
      if (tbl_used[s] == want_used) return s;
    end
    return -1;
  endfunction

  // applies one command to the table mirror and returns the response it owes
  function automatic gsa_pkg::rsp_t alloc_table_apply(input gsa_pkg::req_t r);
    gsa_pkg::rsp_t o;
    int s;
    logic [15:0] g;
    o.ok = 1'b0;
    o.new_handle = gsa_pkg::NO_HANDLE;
    o.slot_index = '0;
    n_cmd[r.command]++;
    case (r.command)
      gsa_pkg::CMD_ALLOC: begin
        s = first_free_slot();
        if (s < 0) begin
          n_refused++;
        end else begin
          // generation skips zero and never reaches all ones
          if (tbl_gen[s] >= gsa_pkg::GEN_WRAP_AT) begin
            g = 16'd1;
          end else begin
            g = tbl_gen[s] + 16'd1;
          end
          tbl_used[s] = 1'b1;
          tbl_gen[s] = g;
          o.ok = 1'b1;
          o.new_handle = mk_handle(g, s);
          o.slot_index = 16'(s);
        end
      end
      gsa_pkg::CMD_RELEASE, gsa_pkg::CMD_LOOKUP: begin
        s = int'(r.handle[15:0]);
        if (r.handle != gsa_pkg::NO_HANDLE && s < SLOTS) begin
          if (tbl_used[s] && tbl_gen[s] == r.handle[31:16]) begin
            if (r.command == gsa_pkg::CMD_RELEASE) tbl_used[s] = 1'b0;
            o.ok = 1'b1;
            o.slot_index = 16'(s);
          end
        end
      end
      default: begin
      end
    endcase
    if (o.ok) n_ok++;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short if the block is badly off
    if (err_count < 40) $display("%0t mismatch on response %0d: %s", $time, n_checked, what);
    err_count++;
  endtask

  // drop valid and stay idle; n sets the length of the gap and is at least one
  task automatic req_idle(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one request transaction and hold it until accepted; unless an idle gap
  // is drawn, valid stays high on return so the next call runs on without a bubble
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] h);
    gsa_pkg::req_t item;
    item.command = cmd;
    item.handle = h;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_ready !== 1'b1) @(posedge clk);
    rsp_owed.push_back(alloc_table_apply(item));
    if (idle_on && $urandom_range(99) < 24) req_idle($urandom_range(1, 3));
  endtask

  // stop offering and wait until every owed response has come back
  task automatic wait_results_settled();
    req_valid <= 1'b0;
    do @(posedge clk); while (rsp_owed.size() != 0);
  endtask

  // mostly allocates and well-formed traffic on live handles, the rest stale, free, noise or an unused code
  task automatic send_random_item();
    int pick;
    int s;
    logic [1:0] chk_cmd;
    pick = $urandom_range(99);
    chk_cmd = $urandom_range(1) ? gsa_pkg::CMD_LOOKUP : gsa_pkg::CMD_RELEASE;
    if (pick < 30) begin
      send_cmd(gsa_pkg::CMD_ALLOC, $urandom);
    end else if (pick < 76) begin
      s = find_slot(1'b1);
      if (s < 0) begin
        send_cmd(gsa_pkg::CMD_ALLOC, $urandom);
      end else if (pick < 50) begin
        send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(tbl_gen[s], s));
      end else if (pick < 68) begin
        send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(tbl_gen[s], s));
      end else begin
        // live slot, one generation bit off
        send_cmd(chk_cmd, mk_handle(tbl_gen[s] ^ (16'h1 << $urandom_range(15)), s));
      end
    end else if (pick < 83) begin
      // freed slot with the generation it last had
      s = find_slot(1'b0);
      if (s < 0) send_cmd(gsa_pkg::CMD_ALLOC, $urandom);
      else send_cmd(chk_cmd, mk_handle(tbl_gen[s], s));
    end else if (pick < 91) begin
      send_cmd(chk_cmd, $urandom);
    end else if (pick < 95) begin
      send_cmd(chk_cmd, mk_handle(16'($urandom), $urandom_range(SLOTS - 1)));
    end else begin
      send_cmd(CMD_UNUSED, $urandom);
    end
  endtask

  // field extremes, each command and each failure kind on a nearly empty table
  task automatic test_directed();
    send_cmd(gsa_pkg::CMD_LOOKUP, 32'h0000_0000);           // never-used slot
    send_cmd(gsa_pkg::CMD_RELEASE, gsa_pkg::NO_HANDLE);     // sentinel
    send_cmd(gsa_pkg::CMD_LOOKUP, gsa_pkg::NO_HANDLE);
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd1, SLOTS)); // first index past the table
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd1, 65535));
    send_cmd(CMD_UNUSED, 32'h0000_0000);
    send_cmd(gsa_pkg::CMD_ALLOC, gsa_pkg::NO_HANDLE);       // handle is ignored on allocate
    send_cmd(gsa_pkg::CMD_ALLOC, 32'h0000_0000);
    send_cmd(gsa_pkg::CMD_ALLOC, 32'h5A5A_A5A5);
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd1, 1));     // live
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd2, 1));     // generation ahead
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd0, 1));     // generation behind
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd1, 1));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd1, 1));    // already free
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd1, 1));
    send_cmd(gsa_pkg::CMD_ALLOC, 32'hFFFF_0000);            // reuses slot 1, new generation
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd2, 1));
    send_cmd(CMD_UNUSED, mk_handle(16'd2, 1));              // unused code must not release
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd2, 1));
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(16'd1, SLOTS - 1));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd1, 0));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd1, 2));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(16'd2, 1));
    wait_results_settled();
  endtask

  // fill every slot, overflow, punch holes and refill lowest first
  task automatic test_table_full();
    int s;
    for (s = 0; s < SLOTS + 2; s++) send_cmd(gsa_pkg::CMD_ALLOC, $urandom);
    send_cmd(gsa_pkg::CMD_LOOKUP, mk_handle(tbl_gen[SLOTS - 1], SLOTS - 1));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(tbl_gen[100], 100));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(tbl_gen[7], 7));
    send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(tbl_gen[SLOTS - 1], SLOTS - 1));
    for (s = 0; s < 4; s++) send_cmd(gsa_pkg::CMD_ALLOC, $urandom);
    // thin out a little so the random mix sees both free and live slots
    for (s = 0; s < SLOTS; s += 8) begin
      if ($urandom_range(1)) send_cmd(gsa_pkg::CMD_RELEASE, mk_handle(tbl_gen[s], s));
    end
    wait_results_settled();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    int n;
    rsp_hold_cycles = 150;
    for (n = 0; n < 30; n++) send_random_item();
    wait_results_settled();
  endtask

  task automatic test_random();
    int n;
    for (n = 0; n < 64; n++) begin
      // a long run with no idling in the middle
      idle_on = !(n >= 8 && n < 56);
      send_random_item();
    end
    idle_on = 1'b1;
    wait_results_settled();
  endtask

  // receiver: random stalls, or a counted hold-off when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_ready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  // response check: every accepted response against the oldest owed one
  initial begin
    gsa_pkg::rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
        if (rsp_owed.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = rsp_owed.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch($sformatf("ok %b, want %b", rsp.ok, want.ok));
          if (rsp.new_handle !== want.new_handle)
            report_mismatch($sformatf("new_handle %h, want %h",
                                      rsp.new_handle, want.new_handle));
          if (rsp.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      rsp.slot_index, want.slot_index));
          n_checked++;
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", rsp_owed.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    int s;
    for (s = 0; s < SLOTS; s++) begin
      tbl_used[s] = 1'b0;
      tbl_gen[s] = 16'd0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random();

    // let any stray response show up
    repeat (20) @(posedge clk);

    $display("%0d responses checked: %0d allocate, %0d release, %0d lookup, %0d unused code",
             n_checked, n_cmd[gsa_pkg::CMD_ALLOC], n_cmd[gsa_pkg::CMD_RELEASE],
             n_cmd[gsa_pkg::CMD_LOOKUP], n_cmd[CMD_UNUSED]);
    $display("%0d succeeded, %0d allocates refused on a full table", n_ok, n_refused);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/gsa_pkg.sv
src/gsa_ctrl.sv
src/gsa_datapath.sv
src/generational_slot_allocator.sv
sim/tb_generational_slot_allocator.sv
